/* hw/rtl/quadrature_count_speed_meter_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature count and speed meter
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_COUNT_SPEED_METER_MACROS_SVH
`define QUADRATURE_COUNT_SPEED_METER_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, held off during reset
`define QCSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qcsm: same-cycle check failed");
// next-cycle implication, held off during reset
`define QCSM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qcsm: next-cycle check failed");
`else
`define QCSM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QCSM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/qcsm_pkg.sv */
// ----------------------------------------------------------------------------
// qcsm_pkg
// Widths, register indexes and the quadrature transition decode shared by
// the count and speed meter files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qcsm_pkg;

    // field and datapath widths
    localparam int CNT_W       = 32;
    localparam int TS_W        = 32;
    localparam int RPM_SCALE_W = 28;
    localparam int DIST_TICK_W = 24;
    localparam int PROD_RPM_W  = CNT_W + RPM_SCALE_W;
    localparam int PROD_DIST_W = CNT_W + DIST_TICK_W;
    localparam int DIST_OUT_W  = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = RPM_SCALE_W;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_RPM_SCALE     = 2'd0;
    localparam t_cfg_idx CFG_DIST_PER_TICK = 2'd1;

    localparam logic [RPM_SCALE_W-1:0] RPM_SCALE_RESET = 28'd87771429;

    // transition codes: {previous A, previous B, current A, current B}
    localparam logic [3:0] TR_DEC_A = 4'b1101;
    localparam logic [3:0] TR_DEC_B = 4'b0100;
    localparam logic [3:0] TR_DEC_C = 4'b0010;
    localparam logic [3:0] TR_DEC_D = 4'b1011;
    localparam logic [3:0] TR_INC_A = 4'b1110;
    localparam logic [3:0] TR_INC_B = 4'b0111;
    localparam logic [3:0] TR_INC_C = 4'b0001;
    localparam logic [3:0] TR_INC_D = 4'b1000;

    typedef struct packed {
        logic dec;
        logic inc;
    } t_step;

    function automatic t_step tr_step(input logic [3:0] code);
        t_step s;
        s.dec = 1'b0;
        s.inc = 1'b0;
        case (code)
            TR_DEC_A, TR_DEC_B, TR_DEC_C, TR_DEC_D: s.dec = 1'b1;
            TR_INC_A, TR_INC_B, TR_INC_C, TR_INC_D: s.inc = 1'b1;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/qcsm_mul.sv */
// ----------------------------------------------------------------------------
// qcsm_mul
// Bit-serial shift-add multiplier: the pulse magnitude times both scale
// registers, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qcsm_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [qcsm_pkg::CNT_W-1:0]          i_mag,
    input  logic [qcsm_pkg::RPM_SCALE_W-1:0]    i_scale,
    input  logic [qcsm_pkg::DIST_TICK_W-1:0]    i_dist,
    output logic                                o_done,
    output logic [qcsm_pkg::PROD_RPM_W-1:0]     o_prod_rpm,
    output logic [qcsm_pkg::PROD_DIST_W-1:0]    o_prod_dist
);
    import qcsm_pkg::*;

    localparam int STEP_W = $clog2(CNT_W);

    logic                   r_busy;
    logic                   r_done;
    logic [STEP_W-1:0]      r_cnt;
    logic [RPM_SCALE_W-1:0] r_hi_r;
    logic [CNT_W-1:0]       r_lo_r;
    logic [DIST_TICK_W-1:0] r_hi_d;
    logic [CNT_W-1:0]       r_lo_d;

    logic [RPM_SCALE_W:0]   sum_r;
    logic [DIST_TICK_W:0]   sum_d;

    // partial sums for the current multiplier bit
    always_comb begin
        sum_r = {1'b0, r_hi_r} + (r_lo_r[0] ? {1'b0, i_scale} : '0);
        sum_d = {1'b0, r_hi_d} + (r_lo_d[0] ? {1'b0, i_dist} : '0);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(CNT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // product shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi_r <= '0;
            r_lo_r <= i_mag;
            r_hi_d <= '0;
            r_lo_d <= i_mag;
        end else if (r_busy) begin
            r_hi_r <= sum_r[RPM_SCALE_W:1];
            r_lo_r <= {sum_r[0], r_lo_r[CNT_W-1:1]};
            r_hi_d <= sum_d[DIST_TICK_W:1];
            r_lo_d <= {sum_d[0], r_lo_d[CNT_W-1:1]};
        end
    end

    assign o_done      = r_done;
    assign o_prod_rpm  = {r_hi_r, r_lo_r};
    assign o_prod_dist = {r_hi_d, r_lo_d};

endmodule

`default_nettype wire

/* hw/rtl/qcsm_div.sv */
// ----------------------------------------------------------------------------
// qcsm_div
// Restoring divider, one quotient bit per cycle: scaled pulses over the
// elapsed microseconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qcsm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [qcsm_pkg::PROD_RPM_W-1:0]     i_dividend,
    input  logic [qcsm_pkg::TS_W-1:0]           i_divisor,
    output logic                                o_done,
    output logic [qcsm_pkg::PROD_RPM_W-1:0]     o_quot
);
    import qcsm_pkg::*;

    localparam int STEP_W = $clog2(PROD_RPM_W);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_cnt;
    logic [TS_W-1:0]       r_rem;
    logic [PROD_RPM_W-1:0] r_quo;

    logic [TS_W:0]         trial;
    logic [TS_W:0]         diff;
    logic                  fits;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        trial = {r_rem, r_quo[PROD_RPM_W-1]};
        diff  = trial - {1'b0, i_divisor};
        fits  = (trial >= {1'b0, i_divisor});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(PROD_RPM_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[TS_W-1:0] : trial[TS_W-1:0];
            r_quo <= {r_quo[PROD_RPM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

/* hw/rtl/quadrature_count_speed_meter.sv */
// ----------------------------------------------------------------------------
// quadrature_count_speed_meter
// Quadrature tick counter for one wheel with speed (rpm, Q8) and distance
// (mm, Q16) reported on each update request.
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_ready   i_mode, i_enc_msb, i_enc_lsb,
//                                            i_timestamp_us
//   result    out        o_valid / i_ready   o_tick_count, o_speed_valid,
//                                            o_rpm_q8, o_distance_q16
//   config    in         i_cfg_wr_en         i_cfg_index, i_cfg_wdata
//
// An edge request enters the pending result on acceptance and moves to
// the output register from S_FIN. An update request runs the bit-serial
// multiplier 32 steps and, with nonzero elapsed time, the restoring
// divider 60 steps. One request is in work at a time; a new one is taken
// while the previous result waits on i_ready. A stalled result only holds
// the finish step. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "quadrature_count_speed_meter_macros.svh"

module quadrature_count_speed_meter (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // request channel
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic                                      i_mode,
    input  logic                                      i_enc_msb,
    input  logic                                      i_enc_lsb,
    input  logic [qcsm_pkg::TS_W-1:0]                 i_timestamp_us,
    // result channel
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic signed [qcsm_pkg::CNT_W-1:0]         o_tick_count,
    output logic                                      o_speed_valid,
    output logic signed [qcsm_pkg::CNT_W-1:0]         o_rpm_q8,
    output logic signed [qcsm_pkg::DIST_OUT_W-1:0]    o_distance_q16,
    // configuration
    input  logic                                      i_cfg_wr_en,
    input  logic [qcsm_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [qcsm_pkg::CFG_DATA_W-1:0]           i_cfg_wdata
);
    import qcsm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;

    logic [RPM_SCALE_W-1:0] r_rpm_scale;
    logic [DIST_TICK_W-1:0] r_dist_tick;

    logic [1:0]             r_last_code;
    logic [CNT_W-1:0]       r_tick_total;
    logic [CNT_W-1:0]       r_ticks_at_upd;
    logic [TS_W-1:0]        r_time_at_upd;

    logic                   r_neg;
    logic [TS_W-1:0]        r_dt;

    logic [CNT_W-1:0]       r_res_tick;
    logic                   r_res_speed;
    logic [CNT_W-1:0]       r_res_rpm;
    logic [DIST_OUT_W-1:0]  r_res_dist;

    logic                   r_out_valid;
    logic [CNT_W-1:0]       r_out_tick;
    logic                   r_out_speed;
    logic [CNT_W-1:0]       r_out_rpm;
    logic [DIST_OUT_W-1:0]  r_out_dist;

    logic                   accept;
    logic                   acc_edge;
    logic                   acc_upd;
    logic                   out_free;
    logic                   load_out;
    t_step                  step;
    logic [CNT_W-1:0]       tick_next;
    logic [CNT_W-1:0]       diff;
    logic [CNT_W-1:0]       mag;
    logic [TS_W-1:0]        dt;

    logic                   mul_done;
    logic [PROD_RPM_W-1:0]  prod_rpm;
    logic [PROD_DIST_W-1:0] prod_dist;
    logic                   div_start;
    logic                   div_done;
    logic [PROD_RPM_W-1:0]  quot;

    logic                   rpm_over;
    logic [CNT_W-1:0]       rpm_sat;
    logic                   dist_over;
    logic [DIST_OUT_W-1:0]  dist_sat;

    // request handshake and edge decode
    always_comb begin
        o_ready   = (r_state == S_IDLE);
        accept    = i_valid && o_ready;
        acc_edge  = accept && !i_mode;
        acc_upd   = accept && i_mode;
        step      = tr_step({r_last_code, i_enc_msb, i_enc_lsb});
        tick_next = step.inc ? r_tick_total + 1'b1 :
                    step.dec ? r_tick_total - 1'b1 : r_tick_total;
        diff      = r_tick_total - r_ticks_at_upd;
        mag       = diff[CNT_W-1] ? (~diff + 1'b1) : diff;
        dt        = i_timestamp_us - r_time_at_upd;
        out_free  = !r_out_valid || i_ready;
        load_out  = (r_state == S_FIN) && out_free;
        div_start = mul_done && (r_dt != '0);
    end

    // rpm: saturate the quotient to signed 32 bits
    always_comb begin
        if (r_neg) begin
            rpm_over = (|quot[PROD_RPM_W-1:CNT_W]) ||
                       (quot[CNT_W-1] && (|quot[CNT_W-2:0]));
            rpm_sat  = rpm_over ? {1'b1, {(CNT_W-1){1'b0}}} : (~quot[CNT_W-1:0] + 1'b1);
        end else begin
            rpm_over = |quot[PROD_RPM_W-1:CNT_W-1];
            rpm_sat  = rpm_over ? {1'b0, {(CNT_W-1){1'b1}}} : quot[CNT_W-1:0];
        end
    end

    // distance: saturate the product to signed 48 bits
    always_comb begin
        if (r_neg) begin
            dist_over = (|prod_dist[PROD_DIST_W-1:DIST_OUT_W]) ||
                        (prod_dist[DIST_OUT_W-1] && (|prod_dist[DIST_OUT_W-2:0]));
            dist_sat  = dist_over ? {1'b1, {(DIST_OUT_W-1){1'b0}}} :
                                    (~prod_dist[DIST_OUT_W-1:0] + 1'b1);
        end else begin
            dist_over = |prod_dist[PROD_DIST_W-1:DIST_OUT_W-1];
            dist_sat  = dist_over ? {1'b0, {(DIST_OUT_W-1){1'b1}}} :
                                    prod_dist[DIST_OUT_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc_edge) begin
                    n_state = S_FIN;
                end else if (acc_upd) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_done) begin
                    n_state = div_start ? S_DIV : S_FIN;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state, configuration and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_rpm_scale    <= RPM_SCALE_RESET;
            r_dist_tick    <= '0;
            r_last_code    <= '0;
            r_tick_total   <= '0;
            r_ticks_at_upd <= '0;
            r_time_at_upd  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_RPM_SCALE) begin
                    r_rpm_scale <= i_cfg_wdata;
                end else if (i_cfg_index == CFG_DIST_PER_TICK) begin
                    r_dist_tick <= i_cfg_wdata[DIST_TICK_W-1:0];
                end
            end
            if (acc_edge) begin
                r_last_code  <= {i_enc_msb, i_enc_lsb};
                r_tick_total <= tick_next;
            end
            if (acc_upd) begin
                r_ticks_at_upd <= r_tick_total;
                r_time_at_upd  <= i_timestamp_us;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // pending result and output register
    always_ff @(posedge i_clk) begin
        if (acc_edge) begin
            r_res_tick  <= tick_next;
            r_res_speed <= 1'b0;
            r_res_rpm   <= '0;
            r_res_dist  <= '0;
        end
        if (acc_upd) begin
            r_res_tick  <= r_tick_total;
            r_res_speed <= 1'b1;
            r_res_rpm   <= '0;
            r_neg       <= diff[CNT_W-1];
            r_dt        <= dt;
        end
        if (mul_done) begin
            r_res_dist <= dist_sat;
        end
        if (div_done) begin
            r_res_rpm <= rpm_sat;
        end
        if (load_out) begin
            r_out_tick  <= r_res_tick;
            r_out_speed <= r_res_speed;
            r_out_rpm   <= r_res_rpm;
            r_out_dist  <= r_res_dist;
        end
    end

    // scale products
    qcsm_mul u_mul (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (acc_upd),
        .i_mag       (mag),
        .i_scale     (r_rpm_scale),
        .i_dist      (r_dist_tick),
        .o_done      (mul_done),
        .o_prod_rpm  (prod_rpm),
        .o_prod_dist (prod_dist)
    );

    // rpm division by elapsed time
    qcsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (prod_rpm),
        .i_divisor  (r_dt),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign o_valid        = r_out_valid;
    assign o_tick_count   = $signed(r_out_tick);
    assign o_speed_valid  = r_out_speed;
    assign o_rpm_q8       = $signed(r_out_rpm);
    assign o_distance_q16 = $signed(r_out_dist);

    // checks
    `QCSM_ASSERT_NXT(a_edge_to_fin, i_clk, i_rst_n, acc_edge, r_state == S_FIN)
    `QCSM_ASSERT_IMP(a_mul_done_in_mul, i_clk, i_rst_n, mul_done, r_state == S_MUL)
    `QCSM_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == S_DIV)
    `QCSM_ASSERT_IMP(a_edge_result_zero, i_clk, i_rst_n, o_valid && !o_speed_valid, (o_rpm_q8 == '0) && (o_distance_q16 == '0))

endmodule

`default_nettype wire
